// File: rtl/core/csnd_pkg.sv
// ----------------------------------------------------------------------------
// csnd_pkg
// Types, constants and codes shared by the color signature note detector.
// ----------------------------------------------------------------------------
`default_nettype none
package csnd_pkg;

  localparam int RATIO_BITS  = 16;
  localparam int QW          = RATIO_BITS + 1;
  localparam int PER_W       = 17;
  localparam int SUM_W       = 19;
  localparam int REM_W       = SUM_W + 1;
  localparam int ACC_W       = 2 * QW + 2;
  localparam int MA_W        = 32;
  localparam int MB_W        = 24;
  localparam int PROD_W      = MA_W + MB_W;
  localparam int KT_W        = 23;
  localparam int LIM_W       = 2 * KT_W;
  localparam int MAX_SIG_DEF = 32;
  localparam int CFG_W       = 19;

  localparam logic [SUM_W-1:0] MIN_SUM_RST   = 19'd30;
  localparam logic [15:0]      CLEAR_HOLD_RST = 16'd1500;
  localparam logic [15:0]      BLOCK_WARN_RST = 16'd5000;
  localparam logic [PER_W-1:0] TIMEOUT_RST   = 17'd9999;
  localparam logic [13:0]      CONF_SCALE    = 14'd10000;
  localparam logic [6:0]       CONF_FULL     = 7'd100;

  typedef enum logic [1:0] {
    REG_MIN_SUM    = 2'd0,
    REG_CLEAR_HOLD = 2'd1,
    REG_BLOCK_WARN = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    EV_SKIPPED  = 4'd0,
    EV_IDLE     = 4'd1,
    EV_DEPOSIT  = 4'd2,
    EV_HELD     = 4'd3,
    EV_BLOCKED  = 4'd4,
    EV_CLR_START = 4'd5,
    EV_CLEARING = 4'd6,
    EV_REARMED  = 4'd7,
    EV_STORED   = 4'd8,
    EV_FULL     = 4'd9
  } ev_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_APPEND, OP_CLEAR, OP_SKIP, OP_DIV_INIT, OP_DIV_STEP,
    OP_READ, OP_MUL_R, OP_MUL_G, OP_MUL_B, OP_MUL_T, OP_NEXT, OP_MUL_LIM,
    OP_BS_INIT, OP_MUL_KT, OP_MUL_KSQ, OP_BS_STEP, OP_HIT, OP_MISS, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_DIV, ST_LOOK, ST_MR, ST_MG, ST_MB, ST_MT, ST_CMP,
    ST_BSI, ST_KM, ST_KS, ST_KC, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic sum_ok;
    logic div_last;
    logic idx_end;
    logic d2_lt;
    logic bs_done;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [PER_W-1:0] red_period;
    logic [PER_W-1:0] green_period;
    logic [PER_W-1:0] blue_period;
    logic [31:0]      time_ms;
    logic [19:0]      sig_nominal;
    logic [15:0]      sig_red_ratio;
    logic [15:0]      sig_green_ratio;
    logic [15:0]      sig_blue_ratio;
    logic [15:0]      sig_tolerance;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [19:0] note_value;
    logic [6:0]  confidence;
    logic [31:0] balance;
    logic [5:0]  table_count;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/csnd_if.sv
// ----------------------------------------------------------------------------
// csnd_in_if / csnd_out_if
// Valid/ready channels carrying one request item or one result item.
// ----------------------------------------------------------------------------
`default_nettype none
interface csnd_in_if import csnd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csnd_out_if import csnd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/csnd_ctrl.sv
// ----------------------------------------------------------------------------
// csnd_ctrl
// Sequencer: divide, walk the signature table, search the confidence, emit.
// ----------------------------------------------------------------------------
`default_nettype none
module csnd_ctrl import csnd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CHECK;
      ST_CHECK: state_next = (stat.cmd == CMD_SAMPLE && stat.sum_ok) ? ST_DIV : ST_EMIT;
      ST_DIV:   if (stat.div_last) state_next = ST_LOOK;
      ST_LOOK:  state_next = stat.idx_end ? ST_EMIT : ST_MR;
      ST_MR:    state_next = ST_MG;
      ST_MG:    state_next = ST_MB;
      ST_MB:    state_next = ST_MT;
      ST_MT:    state_next = ST_CMP;
      ST_CMP:   state_next = stat.d2_lt ? ST_BSI : ST_LOOK;
      ST_BSI:   state_next = ST_KM;
      ST_KM:    state_next = stat.bs_done ? ST_EMIT : ST_KS;
      ST_KS:    state_next = ST_KC;
      ST_KC:    state_next = ST_KM;
      ST_EMIT:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_CHECK: begin
        case (stat.cmd)
          CMD_SAMPLE: cmd.op = stat.sum_ok ? OP_DIV_INIT : OP_SKIP;
          CMD_APPEND: cmd.op = OP_APPEND;
          CMD_CLEAR:  cmd.op = OP_CLEAR;
          default:    cmd.op = OP_SKIP;
        endcase
      end
      ST_DIV:  cmd.op = OP_DIV_STEP;
      ST_LOOK: cmd.op = stat.idx_end ? OP_MISS : OP_READ;
      ST_MR:   cmd.op = OP_MUL_R;
      ST_MG:   cmd.op = OP_MUL_G;
      ST_MB:   cmd.op = OP_MUL_B;
      ST_MT:   cmd.op = OP_MUL_T;
      ST_CMP:  cmd.op = stat.d2_lt ? OP_MUL_LIM : OP_NEXT;
      ST_BSI:  cmd.op = OP_BS_INIT;
      ST_KM:   cmd.op = stat.bs_done ? OP_HIT : OP_MUL_KT;
      ST_KS:   cmd.op = OP_MUL_KSQ;
      ST_KC:   cmd.op = OP_BS_STEP;
      ST_EMIT: if (stat.out_free) cmd.op = OP_EMIT;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/csnd_dp.sv
// ----------------------------------------------------------------------------
// csnd_dp
// Datapath: config registers, ratio divider, signature memory, shared
// multiplier, confidence search, debounce state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module csnd_dp import csnd_pkg::*; #(
  parameter int MAX_SIGNATURES = MAX_SIG_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  ctrl_cmd_t             cmd,
  output dp_stat_t              stat
);

  localparam int IW = (MAX_SIGNATURES > 1) ? $clog2(MAX_SIGNATURES) : 1;
  localparam int CW = $clog2(MAX_SIGNATURES + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_SIGNATURES);

  logic [SUM_W-1:0] min_sum;
  logic [15:0]      clear_hold;
  logic [15:0]      block_warn;
  logic [PER_W-1:0] timeout_p;

  cmd_t             cmd_r;
  logic [PER_W-1:0] per [3];
  logic [SUM_W-1:0] sum;
  logic [31:0]      now;
  logic [19:0]      s_val;
  logic [15:0]      s_r, s_g, s_b, s_t;

  logic [1:0]       ch;
  logic [4:0]       cnt;
  logic [REM_W-1:0] rem;
  logic [QW-1:0]    quo;
  logic [QW-1:0]    ratio [3];

  logic [47:0]      rat_mem [MAX_SIGNATURES];
  logic [35:0]      vt_mem  [MAX_SIGNATURES];
  logic [47:0]      rd_rat;
  logic [35:0]      rd_vt;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;

  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic [LIM_W-1:0]  lim;
  logic [6:0]        lo, hi;

  logic        waiting, clr_timing;
  logic [31:0] dep_time, clr_start, bal;
  ev_t         ev;
  logic [19:0] note;
  logic [6:0]  conf;

  function automatic logic [PER_W-1:0] fix_p(input logic [PER_W-1:0] p,
                                             input logic [PER_W-1:0] tmo);
    return (p == '0) ? tmo : p;
  endfunction

  function automatic logic [QW-1:0] absdiff(input logic [QW-1:0] a,
                                            input logic [QW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic             ge;
  logic [REM_W-1:0] rem_sub;
  logic [QW-1:0]    quo_n;
  logic [REM_W-1:0] rem_nxt_ch;
  logic [QW-1:0]    dr, dg, db;
  logic [15:0]      t_rd;
  logic [7:0]       lohi;
  logic [6:0]       mid;
  logic [31:0]      dep_el, clr_el;

  assign ge      = rem >= REM_W'(sum);
  assign rem_sub = ge ? rem - REM_W'(sum) : rem;
  assign quo_n   = {quo[QW-2:0], ge};
  always_comb begin
    case (ch)
      2'd0:    rem_nxt_ch = REM_W'(per[1]);
      default: rem_nxt_ch = REM_W'(per[2]);
    endcase
  end

  assign dr   = absdiff(ratio[0], QW'(rd_rat[47:32]));
  assign dg   = absdiff(ratio[1], QW'(rd_rat[31:16]));
  assign db   = absdiff(ratio[2], QW'(rd_rat[15:0]));
  assign t_rd = rd_vt[15:0];
  assign lohi = {1'b0, lo} + {1'b0, hi};
  assign mid  = lohi[7:1];
  assign dep_el = now - dep_time;
  assign clr_el = now - clr_start;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_R:   begin mul_a = MA_W'(dr); mul_b = MB_W'(dr); end
      OP_MUL_G:   begin mul_a = MA_W'(dg); mul_b = MB_W'(dg); end
      OP_MUL_B:   begin mul_a = MA_W'(db); mul_b = MB_W'(db); end
      OP_MUL_T:   begin mul_a = MA_W'(t_rd); mul_b = MB_W'(t_rd); end
      OP_MUL_LIM: begin mul_a = acc[31:0]; mul_b = MB_W'(CONF_SCALE); end
      OP_MUL_KT:  begin mul_a = MA_W'(t_rd); mul_b = MB_W'(mid); end
      OP_MUL_KSQ: begin mul_a = MA_W'(prod[KT_W-1:0]); mul_b = MB_W'(prod[KT_W-1:0]); end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_sum    <= MIN_SUM_RST;
      clear_hold <= CLEAR_HOLD_RST;
      block_warn <= BLOCK_WARN_RST;
      timeout_p  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MIN_SUM:    min_sum    <= cfg_data;
        REG_CLEAR_HOLD: clear_hold <= cfg_data[15:0];
        REG_BLOCK_WARN: block_warn <= cfg_data[15:0];
        REG_TIMEOUT:    timeout_p  <= cfg_data[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        cmd_r  <= cmd_t'(in_data.cmd);
        per[0] <= fix_p(in_data.red_period, timeout_p);
        per[1] <= fix_p(in_data.green_period, timeout_p);
        per[2] <= fix_p(in_data.blue_period, timeout_p);
        sum    <= SUM_W'(fix_p(in_data.red_period, timeout_p))
                + SUM_W'(fix_p(in_data.green_period, timeout_p))
                + SUM_W'(fix_p(in_data.blue_period, timeout_p));
        now    <= in_data.time_ms;
        s_val  <= in_data.sig_nominal;
        s_r    <= in_data.sig_red_ratio;
        s_g    <= in_data.sig_green_ratio;
        s_b    <= in_data.sig_blue_ratio;
        s_t    <= in_data.sig_tolerance;
      end
      OP_DIV_INIT: begin
        ch  <= 2'd0;
        cnt <= '0;
        rem <= REM_W'(per[0]);
        quo <= '0;
        idx <= '0;
      end
      OP_DIV_STEP: begin
        if (cnt == 5'(RATIO_BITS)) begin
          ratio[ch] <= quo_n;
          ch  <= ch + 2'd1;
          cnt <= '0;
          rem <= rem_nxt_ch;
          quo <= '0;
        end else begin
          rem <= {rem_sub[REM_W-2:0], 1'b0};
          quo <= quo_n;
          cnt <= cnt + 5'd1;
        end
      end
      OP_READ: begin
        rd_rat <= rat_mem[idx[IW-1:0]];
        rd_vt  <= vt_mem[idx[IW-1:0]];
      end
      OP_MUL_G:   acc <= ACC_W'(prod);
      OP_MUL_B:   acc <= acc + ACC_W'(prod);
      OP_MUL_T:   acc <= acc + ACC_W'(prod);
      OP_NEXT:    idx <= idx + CW'(1);
      OP_BS_INIT: begin
        lim <= prod[LIM_W-1:0];
        lo  <= '0;
        hi  <= CONF_FULL;
      end
      OP_BS_STEP: begin
        if (prod[LIM_W-1:0] >= lim) hi <= mid;
        else                        lo <= mid + 7'd1;
      end
      default: ;
    endcase
    if (cmd.op == OP_APPEND && count != CMAX) begin
      rat_mem[count[IW-1:0]] <= {s_r, s_g, s_b};
      vt_mem[count[IW-1:0]]  <= {s_val, s_t};
    end
  end

  // result fields of the current request
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_APPEND: begin
        ev <= (count != CMAX) ? EV_STORED : EV_FULL;
        note <= '0; conf <= '0;
      end
      OP_CLEAR: begin ev <= EV_FULL; note <= '0; conf <= '0; end
      OP_SKIP:  begin ev <= EV_SKIPPED; note <= '0; conf <= '0; end
      OP_HIT: begin
        note <= rd_vt[35:16];
        conf <= CONF_FULL - lo;
        if (!waiting) ev <= EV_DEPOSIT;
        else          ev <= (dep_el > 32'(block_warn)) ? EV_BLOCKED : EV_HELD;
      end
      OP_MISS: begin
        note <= '0; conf <= '0;
        if (!waiting)                      ev <= EV_IDLE;
        else if (!clr_timing)              ev <= EV_CLR_START;
        else if (clr_el > 32'(clear_hold)) ev <= EV_REARMED;
        else                               ev <= EV_CLEARING;
      end
      default: ;
    endcase
  end

  // debounce and table control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      waiting    <= 1'b0;
      clr_timing <= 1'b0;
      dep_time   <= '0;
      clr_start  <= '0;
      bal        <= '0;
    end else begin
      case (cmd.op)
        OP_APPEND: if (count != CMAX) count <= count + CW'(1);
        OP_CLEAR:  count <= '0;
        OP_HIT: begin
          clr_timing <= 1'b0;
          if (!waiting) begin
            bal      <= bal + 32'(rd_vt[35:16]);
            waiting  <= 1'b1;
            dep_time <= now;
          end
        end
        OP_MISS: begin
          if (waiting) begin
            if (!clr_timing) begin
              clr_timing <= 1'b1;
              clr_start  <= now;
            end else if (clr_el > 32'(clear_hold)) begin
              waiting    <= 1'b0;
              clr_timing <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_data.event_res   <= ev;
      out_data.note_value  <= note;
      out_data.confidence  <= conf;
      out_data.balance     <= bal;
      out_data.table_count <= 6'(count);
    end
  end

  assign stat.cmd      = cmd_r;
  assign stat.sum_ok   = (sum != '0) && (sum >= min_sum);
  assign stat.div_last = (cnt == 5'(RATIO_BITS)) && (ch == 2'd2);
  assign stat.idx_end  = (idx == count);
  assign stat.d2_lt    = acc < ACC_W'(prod);
  assign stat.bs_done  = (lo == hi);
  assign stat.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

// File: rtl/core/color_signature_note_detector_core.sv
// Append, clear, skipped or unused requests go from the check state straight to the result register;
// a sample runs three 17-step ratio divisions, then for each signature checked a read, the three
// color squares, the tolerance square and a compare, and on a match a confidence binary search.
// A new request is taken only after the previous one reaches the result register, also while a result waits.
// Synchronous active-high reset clears control state and loads register defaults;
// the signature memory is not cleared, entries are read only after being written.
// ----------------------------------------------------------------------------
// color_signature_note_detector_core
// Matches color pulse periods against stored signatures and debounces deposits.
// ----------------------------------------------------------------------------
`default_nettype none
module color_signature_note_detector_core import csnd_pkg::*; #(
  parameter int MAX_SIGNATURES = MAX_SIG_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  csnd_in_if.sink               in_ch,
  csnd_out_if.source            out_ch
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  csnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  csnd_dp #(.MAX_SIGNATURES(MAX_SIGNATURES)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_ch.data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives sample, append, clear and unused requests into the color signature
// note detector under random idling on both channels and register settings
// that include the extremes. A scoreboard predicts every result and checks
// it field by field against the block's output.
// ----------------------------------------------------------------------------
module testbench;
  import csnd_pkg::*;

  class note_ledger;
    logic [SUM_W-1:0] min_sum;
    logic [15:0]      hold_ms;
    logic [15:0]      warn_ms;
    logic [PER_W-1:0] tmo_per;
    logic [15:0]      sig_r [MAX_SIG_DEF];
    logic [15:0]      sig_g [MAX_SIG_DEF];
    logic [15:0]      sig_b [MAX_SIG_DEF];
    logic [15:0]      sig_t [MAX_SIG_DEF];
    logic [19:0]      sig_v [MAX_SIG_DEF];
    int unsigned      sig_cnt;
    bit               waiting;
    bit               clr_timing;
    logic [31:0]      dep_time;
    logic [31:0]      clr_time;
    logic [31:0]      bal;
    out_item_t        want_q[$];
    int               errors;

    function new();
      min_sum = MIN_SUM_RST;
      hold_ms = CLEAR_HOLD_RST;
      warn_ms = BLOCK_WARN_RST;
      tmo_per = TIMEOUT_RST;
      sig_cnt = 0;
      waiting = 0;
      clr_timing = 0;
      dep_time = 0;
      clr_time = 0;
      bal = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_MIN_SUM:    min_sum = v;
        REG_CLEAR_HOLD: hold_ms = v[15:0];
        REG_BLOCK_WARN: warn_ms = v[15:0];
        REG_TIMEOUT:    tmo_per = v[PER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint unsigned fixed_period(logic [PER_W-1:0] p);
      return (p == 0) ? longint'(tmo_per) : longint'(p);
    endfunction

    function longint unsigned sq_gap(longint unsigned a, longint unsigned b);
      longint unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
    endfunction

    function void note_request(in_item_t it);
      out_item_t o;
      longint unsigned r, g, b, s, qr, qg, qb, t, d2, lim;
      int unsigned k;
      bit hit;
      o = '0;
      o.event_res = EV_SKIPPED;
      case (cmd_t'(it.cmd))
        CMD_APPEND: begin
          if (sig_cnt < MAX_SIG_DEF) begin
            sig_v[sig_cnt] = it.sig_nominal;
            sig_r[sig_cnt] = it.sig_red_ratio;
            sig_g[sig_cnt] = it.sig_green_ratio;
            sig_b[sig_cnt] = it.sig_blue_ratio;
            sig_t[sig_cnt] = it.sig_tolerance;
            sig_cnt++;
            o.event_res = EV_STORED;
          end else begin
            o.event_res = EV_FULL;
          end
        end
        CMD_CLEAR: begin
          sig_cnt = 0;
          o.event_res = EV_FULL;
        end
        CMD_SAMPLE: begin
          r = fixed_period(it.red_period);
          g = fixed_period(it.green_period);
          b = fixed_period(it.blue_period);
          s = r + g + b;
          if (s != 0 && s >= min_sum) begin
            qr = (r << RATIO_BITS) / s;
            qg = (g << RATIO_BITS) / s;
            qb = (b << RATIO_BITS) / s;
            hit = 0;
            for (int i = 0; i < sig_cnt && !hit; i++) begin
              t = sig_t[i];
              d2 = sq_gap(qr, sig_r[i]) + sq_gap(qg, sig_g[i]) + sq_gap(qb, sig_b[i]);
              if (d2 < t * t) begin
                lim = 10000 * d2;
                k = 0;
                while (k < 100 && (k * t) * (k * t) < lim) k++;
                hit = 1;
                o.note_value = sig_v[i];
                o.confidence = 100 - k;
              end
            end
            if (hit) begin
              if (!waiting) begin
                bal = bal + o.note_value;
                waiting = 1;
                dep_time = it.time_ms;
                clr_timing = 0;
                o.event_res = EV_DEPOSIT;
              end else begin
                clr_timing = 0;
                o.event_res = (it.time_ms - dep_time > warn_ms) ? EV_BLOCKED : EV_HELD;
              end
            end else if (!waiting) begin
              o.event_res = EV_IDLE;
            end else if (!clr_timing) begin
              clr_timing = 1;
              clr_time = it.time_ms;
              o.event_res = EV_CLR_START;
            end else if (it.time_ms - clr_time > hold_ms) begin
              waiting = 0;
              clr_timing = 0;
              o.event_res = EV_REARMED;
            end else begin
              o.event_res = EV_CLEARING;
            end
          end
        end
        default: ;
      endcase
      o.balance = bal;
      o.table_count = sig_cnt;
      want_q.push_back(o);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t w;
      if (want_q.size() == 0) begin
        report("unexpected result, event", got.event_res, 0);
      end else begin
        w = want_q.pop_front();
        if (got.event_res !== w.event_res) report("event_res", got.event_res, w.event_res);
        if (got.note_value !== w.note_value) report("note_value", got.note_value, w.note_value);
        if (got.confidence !== w.confidence) report("confidence", got.confidence, w.confidence);
        if (got.balance !== w.balance) report("balance", got.balance, w.balance);
        if (got.table_count !== w.table_count)
          report("table_count", got.table_count, w.table_count);
      end
    endtask
  endclass

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_we = 0;
  logic [1:0]       cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  csnd_in_if  in_ch ();
  csnd_out_if out_ch ();

  color_signature_note_detector_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  note_ledger ledger = new();

  bit          quiet = 0;
  int          hold_off = 0;
  int          stall = 0;
  logic [31:0] now_ms = 0;
  int          gen_cnt = 0;
  logic [PER_W-1:0] gen_p [MAX_SIG_DEF][3];

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) stall = quiet ? 0 : $urandom_range(0, 14);
      else if (stall > 0) stall--;
      if (hold_off > 0) hold_off--;
      out_ch.ready <= (stall == 0 && hold_off == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) ledger.note_request(in_ch.data);
      if (out_ch.valid && out_ch.ready) ledger.check_result(out_ch.data);
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  task send(in_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (ledger.want_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, logic [CFG_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    ledger.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task set_all(logic [CFG_W-1:0] ms, logic [CFG_W-1:0] hm, logic [CFG_W-1:0] wm,
               logic [CFG_W-1:0] tp);
    write_reg(REG_MIN_SUM, ms);
    write_reg(REG_CLEAR_HOLD, hm);
    write_reg(REG_BLOCK_WARN, wm);
    write_reg(REG_TIMEOUT, tp);
  endtask

  function in_item_t sample_req(logic [PER_W-1:0] r, logic [PER_W-1:0] g,
                                logic [PER_W-1:0] b);
    in_item_t it;
    it = '0;
    it.cmd = CMD_SAMPLE;
    it.red_period = r;
    it.green_period = g;
    it.blue_period = b;
    it.sig_nominal = $urandom;
    it.sig_tolerance = $urandom;
    now_ms = now_ms + $urandom_range(0, 2400);
    if ($urandom_range(0, 40) == 0) now_ms = $urandom;
    it.time_ms = now_ms;
    return it;
  endfunction

  function in_item_t cmd_req(cmd_t c);
    in_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it.cmd = c;
    it.time_ms = now_ms;
    return it;
  endfunction

  function logic [15:0] ratio_of(logic [PER_W-1:0] p, longint unsigned s);
    return (longint'(p) << RATIO_BITS) / s;
  endfunction

  // signature learned from a period triple, with a little jitter
  task add_signature(logic [15:0] tol);
    in_item_t it;
    logic [PER_W-1:0] p [3];
    longint unsigned s;
    for (int c = 0; c < 3; c++) p[c] = $urandom_range(50, 40000);
    s = p[0] + p[1] + p[2];
    it = cmd_req(CMD_APPEND);
    it.sig_red_ratio = ratio_of(p[0], s) + $urandom_range(0, 40) - 20;
    it.sig_green_ratio = ratio_of(p[1], s) + $urandom_range(0, 40) - 20;
    it.sig_blue_ratio = ratio_of(p[2], s) + $urandom_range(0, 40) - 20;
    it.sig_tolerance = tol;
    if (gen_cnt < MAX_SIG_DEF) begin
      gen_p[gen_cnt] = p;
      gen_cnt++;
    end
    send(it);
  endtask

  task match_sample();
    int idx;
    logic [PER_W-1:0] p [3];
    idx = $urandom_range(0, gen_cnt - 1);
    for (int c = 0; c < 3; c++) p[c] = gen_p[idx][c] + $urandom_range(0, 6) - 3;
    send(sample_req(p[0], p[1], p[2]));
  endtask

  task random_sample();
    logic [PER_W-1:0] p [3];
    for (int c = 0; c < 3; c++)
      p[c] = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 131071);
    send(sample_req(p[0], p[1], p[2]));
  endtask

  task random_phase(int n);
    int cnt, sel, run;
    in_item_t it;
    cnt = 0;
    while (cnt < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        send(cmd_req(CMD_CLEAR));
        gen_cnt = 0;
        cnt++;
      end else if (sel < 6) begin
        send(cmd_req(CMD_RSVD));
        cnt++;
      end else if (sel < 8) begin
        it = cmd_req(CMD_APPEND);
        send(it);
        if (gen_cnt < MAX_SIG_DEF) begin
          gen_p[gen_cnt] = '{0, 0, 0};
          gen_cnt++;
        end
        cnt++;
      end else if (sel < 10) begin
        run = $urandom_range(1, 36);
        repeat (run) add_signature($urandom_range(300, 5000));
        cnt += run;
      end else if (sel < 16 || gen_cnt == 0) begin
        add_signature(($urandom_range(0, 20) == 0) ? $urandom_range(0, 1) :
                      $urandom_range(200, 6000));
        cnt++;
      end else if (sel < 70) begin
        run = $urandom_range(1, 8);
        repeat (run) match_sample();
        cnt += run;
      end else begin
        random_sample();
        cnt++;
      end
    end
  endtask

  initial begin
    in_item_t it;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_all(MIN_SUM_RST, CLEAR_HOLD_RST, BLOCK_WARN_RST, TIMEOUT_RST);
    send(cmd_req(CMD_RSVD));
    send(cmd_req(CMD_CLEAR));
    send(sample_req(0, 0, 0));
    send(sample_req(5, 10, 14));
    send(sample_req('1, '1, '1));
    it = cmd_req(CMD_APPEND);
    it.sig_nominal = '1;
    it.sig_red_ratio = '1;
    it.sig_green_ratio = '1;
    it.sig_blue_ratio = '1;
    it.sig_tolerance = '1;
    send(it);
    it.sig_nominal = 0;
    it.sig_red_ratio = 0;
    it.sig_green_ratio = 0;
    it.sig_blue_ratio = 0;
    it.sig_tolerance = 0;
    send(it);
    it.sig_tolerance = 1;
    send(it);
    gen_cnt = 3;
    gen_p[0] = '{0, 0, 0};
    gen_p[1] = '{0, 0, 0};
    gen_p[2] = '{0, 0, 0};
    add_signature(2621);
    gen_p[0] = gen_p[3];
    gen_cnt = 1;
    now_ms = 32'hFFFF_F000;
    match_sample();
    match_sample();
    now_ms = now_ms + 6000;
    match_sample();
    send(sample_req(1, 1, 131071));
    send(sample_req(1, 1, 131071));
    send(sample_req(1, 1, 131071));
    now_ms = now_ms + 2000;
    send(sample_req(1, 1, 131071));
    match_sample();
    send(sample_req(1, 131071, 1));
    drain();

    set_all(0, 0, 0, 0);
    send(sample_req(0, 0, 0));
    send(sample_req(0, 0, 1));
    random_phase(150);
    hold_off = 3000;
    random_phase(30);
    drain();

    quiet = 1;
    set_all(19'h7FFFF, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    random_phase(40);
    drain();

    set_all(MIN_SUM_RST, 16'hFFFF, 16'hFFFF, 17'h1FFFF);
    random_phase(200);
    drain();

    quiet = 0;
    set_all(MIN_SUM_RST, CLEAR_HOLD_RST, BLOCK_WARN_RST, TIMEOUT_RST);
    random_phase(200);
    drain();
    random_phase(100);
    drain();

    set_all($urandom_range(0, 393215), $urandom_range(0, 4000), $urandom_range(0, 9000),
            $urandom_range(0, 131071));
    random_phase(200);
    drain();

    set_all(1, 1, 1, 1);
    random_phase(150);
    drain();

    if (ledger.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
